/* rtl/msu_pkg.sv */
`default_nettype none

package msu_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic signed [DATA_W-1:0] value_t;

endpackage

`default_nettype wire

/* rtl/msu_stream_if.sv */
`default_nettype none

interface msu_item_if;
	logic            valid;
	logic            ready;
	msu_pkg::value_t item_value;
	logic            item_last;

	modport source (output valid, output item_value, output item_last, input ready);
	modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

interface msu_result_if;
	logic            valid;
	logic            ready;
	msu_pkg::value_t sorted_value;
	logic            sorted_last;
	logic            dropped_flag;

	modport source (output valid, output sorted_value, output sorted_last,
		output dropped_flag, input ready);
	modport sink   (input valid, input sorted_value, input sorted_last,
		input dropped_flag, output ready);
endinterface

`default_nettype wire

/* rtl/msu_ram.sv */
`default_nettype none

module msu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/merge_insertion_sorter_unit.sv */
// Load: an item is written directly when the store is empty, dropped (overflow set) when it is full,
// else shifted in from the top: stored values greater than it move up one RAM entry per cycle.
// Drain: each result is read from RAM, loaded into the output register and transferred before the next read.
// Reset (arst_n low): store empty, overflow clear, no result pending; RAM not cleared.
`default_nettype none

module merge_insertion_sorter_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	msu_item_if.sink      item,
	msu_result_if.source  result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_PLACE = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]       state_q;
	msu_pkg::count_t  count_q;
	logic             overflow_q;
	msu_pkg::addr_t   k_q;
	msu_pkg::addr_t   e_q;
	msu_pkg::value_t  val_q;
	logic             last_q;

	logic             pend_s1;
	logic             pend_last_s1;
	logic             pend_drop_s1;

	logic             out_valid_q;
	msu_pkg::value_t  out_value_q;
	logic             out_last_q;
	logic             out_drop_q;

	logic             ram_we;
	msu_pkg::addr_t   ram_waddr;
	msu_pkg::value_t  ram_wdata;
	logic             ram_re;
	msu_pkg::addr_t   ram_raddr;
	msu_pkg::value_t  ram_rdata;

	logic             in_xfer;
	logic             out_xfer;
	logic             room;
	logic             gt;
	logic             emit_rd;
	logic             emit_end;
	msu_pkg::count_t  count_m1;
	msu_pkg::addr_t   k_p1;
	msu_pkg::addr_t   k_m1;

	assign in_xfer  = item.valid && item.ready;
	assign out_xfer = out_valid_q && result.ready;
	assign room     = count_q < msu_pkg::CNT_W'(msu_pkg::MAX_ITEMS);
	assign gt       = ram_rdata > val_q;
	assign count_m1 = count_q - 1'b1;
	assign k_p1     = k_q + 1'b1;
	assign k_m1     = k_q - 1'b1;
	assign emit_rd  = (state_q == ST_EMIT) && !out_valid_q && !pend_s1;
	assign emit_end = ({1'b0, e_q} + 1'b1) == msu_pkg::CNT_W'(count_q);

	assign item.ready          = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.sorted_value = out_value_q;
	assign result.sorted_last  = out_last_q;
	assign result.dropped_flag = out_drop_q;

	msu_ram #(
		.WIDTH (msu_pkg::DATA_W),
		.DEPTH (msu_pkg::MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && room) begin
					if (count_q == '0) begin
						ram_we    = 1'b1;
						ram_wdata = item.item_value;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = count_m1[msu_pkg::ADDR_W-1:0];
					end
				end
			end
			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = k_p1;
				if (gt) begin
					ram_wdata = ram_rdata;
					if (k_q != '0) begin
						ram_re    = 1'b1;
						ram_raddr = k_m1;
					end
				end else begin
					ram_wdata = val_q;
				end
			end
			ST_PLACE: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
			end
			ST_EMIT: begin
				ram_re    = emit_rd;
				ram_raddr = e_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= emit_rd;
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (!room) begin
							overflow_q <= 1'b1;
							if (item.item_last) begin
								state_q <= ST_EMIT;
							end
						end else if (count_q == '0) begin
							count_q <= count_q + 1'b1;
							if (item.item_last) begin
								state_q <= ST_EMIT;
							end
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (gt && k_q == '0) begin
						state_q <= ST_PLACE;
					end else if (!gt) begin
						count_q <= count_q + 1'b1;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + 1'b1;
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_rd && emit_end) begin
						count_q    <= '0;
						overflow_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			val_q  <= item.item_value;
			last_q <= item.item_last;
			k_q    <= count_m1[msu_pkg::ADDR_W-1:0];
			e_q    <= '0;
		end else if (state_q == ST_SHIFT && gt) begin
			k_q <= k_m1;
		end
		if (emit_rd) begin
			e_q          <= e_q + 1'b1;
			pend_last_s1 <= emit_end;
			pend_drop_s1 <= overflow_q;
		end
		if (pend_s1) begin
			out_value_q <= ram_rdata;
			out_last_q  <= pend_last_s1;
			out_drop_q  <= pend_drop_s1;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= msu_pkg::CNT_W'(msu_pkg::MAX_ITEMS))
		else $error("stored count beyond capacity");

	a_pend_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("read issued while output register full");

	a_pend_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> out_valid_q)
		else $error("pending read not loaded into output register");

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> ({1'b0, k_q} < count_q))
		else $error("shift index outside stored range");

endmodule

`default_nettype wire

/* tb/sv/tb_merge_insertion_sorter_unit.sv */
`timescale 1ns / 1ps

module tb_merge_insertion_sorter_unit;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int TAIL_CYCLES    = 100;
	localparam int SMALL_BUDGET   = 70;

	localparam msu_pkg::value_t VALUE_MIN = 32'sh8000_0000;
	localparam msu_pkg::value_t VALUE_MAX = 32'sh7fff_ffff;

	typedef enum int {MIX_FULL, MIX_CLUSTER, MIX_EDGE} value_mix_t;

	typedef struct {
		msu_pkg::value_t value;
		logic            tail;
	} seq_item_t;

	typedef struct {
		msu_pkg::value_t value;
		logic            tail;
		logic            dropped;
	} sorted_word_t;

	logic clk;
	logic arst_n;

	msu_item_if   item_ch();
	msu_result_if result_ch();

	merge_insertion_sorter_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	seq_item_t       item_queue[$];
	sorted_word_t    pending_sorted[$];
	msu_pkg::value_t sort_store[$];
	logic            store_overflow = 1'b0;

	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	bit  item_took = 0;
	bit  timed_out = 0;
	bit  long_hold_done = 0;
	int  hold_left = 0;
	int  idle_cycles = 0;
	int  mismatches = 0;
	int  items_in = 0;
	int  results_seen = 0;
	int  sequences_done = 0;
	int  overflowed_sequences = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Insert into the running ascending store; flush it on the tail transfer.
	function automatic void apply_item_to_sorter(msu_pkg::value_t v, logic tail);
		int           slot;
		sorted_word_t word;
		slot = 0;
		items_in++;
		if (sort_store.size() < msu_pkg::MAX_ITEMS) begin
			while (slot < sort_store.size() && sort_store[slot] <= v)
				slot++;
			sort_store.insert(slot, v);
		end else begin
			store_overflow = 1'b1;
		end
		if (tail) begin
			foreach (sort_store[k]) begin
				word.value   = sort_store[k];
				word.tail    = (k == sort_store.size() - 1);
				word.dropped = store_overflow;
				pending_sorted.insert(pending_sorted.size(), word);
			end
			sequences_done++;
			if (store_overflow)
				overflowed_sequences++;
			sort_store.delete();
			store_overflow = 1'b0;
		end
	endfunction

	function automatic msu_pkg::value_t rand_value(value_mix_t mix);
		msu_pkg::value_t v;
		case (mix)
			MIX_CLUSTER: begin
				v = $urandom_range(8);
				v = v - 4;
			end
			MIX_EDGE: begin
				case ($urandom_range(4))
					0: v = VALUE_MIN;
					1: v = VALUE_MAX;
					2: v = 0;
					3: v = -1;
					default: v = $urandom;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic push_value(msu_pkg::value_t v, logic tail);
		seq_item_t it;
		it.value = v;
		it.tail  = tail;
		item_queue.insert(item_queue.size(), it);
	endtask

	task automatic push_sequence(int len, value_mix_t mix);
		for (int i = 0; i < len; i++)
			push_value(rand_value(mix), i == len - 1);
	endtask

	task automatic wait_drained();
		while (!timed_out && (item_queue.size() != 0 || pending_sorted.size() != 0))
			@(posedge clk);
	endtask

	// Sender: hold an offered item until its transfer, then advance.
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_took)
				void'(item_queue.pop_front());
			if (!(item_ch.valid && !item_took)) begin
				if (item_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					item_ch.valid      <= 1'b1;
					item_ch.item_value <= item_queue[0].value;
					item_ch.item_last  <= item_queue[0].tail;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls plus one long hold while the sender keeps offering.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && results_seen >= 30) begin
				long_hold_done = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		sorted_word_t want;
		bit           result_took;
		if (arst_n) begin
			item_took   = item_ch.valid && item_ch.ready;
			result_took = result_ch.valid && result_ch.ready;
			if (item_took)
				apply_item_to_sorter(item_ch.item_value, item_ch.item_last);
			if (result_took) begin
				results_seen++;
				if (pending_sorted.size() == 0) begin
					$error("unexpected result: sorted_value %0d", result_ch.sorted_value);
					mismatches++;
				end else begin
					want = pending_sorted.pop_front();
					if (result_ch.sorted_value !== want.value) begin
						$error("sorted_value: expected %0d, got %0d", want.value,
							result_ch.sorted_value);
						mismatches++;
					end
					if (result_ch.sorted_last !== want.tail) begin
						$error("sorted_last: expected %0b, got %0b", want.tail,
							result_ch.sorted_last);
						mismatches++;
					end
					if (result_ch.dropped_flag !== want.dropped) begin
						$error("dropped_flag: expected %0b, got %0b", want.dropped,
							result_ch.dropped_flag);
						mismatches++;
					end
				end
			end
			if (item_took || result_took)
				idle_cycles = 0;
			else if (++idle_cycles >= WATCHDOG_LIMIT)
				timed_out = 1;
		end
	end

	initial begin
		int         pushed;
		int         len;
		value_mix_t mix;
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.item_value   = '0;
		item_ch.item_last    = 1'b0;
		result_ch.ready      = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 3 && !timed_out; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 16;
					rx_idle_pct = 48;
				end
				1: begin
					tx_idle_pct = 48;
					rx_idle_pct = 16;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase

			if (phase == 0) begin
				push_value(VALUE_MIN, 1'b1);
				push_value(VALUE_MAX, 1'b1);
				push_value(0, 1'b1);
				push_value(VALUE_MAX, 1'b0);
				push_value(VALUE_MIN, 1'b0);
				push_value(0, 1'b0);
				push_value(-1, 1'b0);
				push_value(1, 1'b0);
				push_value(VALUE_MIN + 1, 1'b0);
				push_value(VALUE_MAX - 1, 1'b1);
				for (int i = 0; i < 4; i++)
					push_value(7, i == 3);
				for (int i = 5; i >= 1; i--)
					push_value(i, i == 1);
				push_value(-3, 1'b0);
				push_value(-2, 1'b0);
				push_value(-1, 1'b1);
			end

			// Full store exactly, then tail dropped at full, then the last six values lost.
			push_sequence(msu_pkg::MAX_ITEMS + (phase == 0 ? 0 : (phase == 1 ? 1 : 6)),
				value_mix_t'($urandom_range(2)));

			pushed = 0;
			while (pushed < SMALL_BUDGET) begin
				len = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
				mix = value_mix_t'($urandom_range(2));
				push_sequence(len, mix);
				pushed += len;
			end
			wait_drained();
		end

		if (!timed_out)
			repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_sorted.size() != 0) begin
			$error("%0d sorted values never arrived", pending_sorted.size());
			mismatches++;
		end

		$display("Sorted %0d sequences: %0d values in, %0d values out.",
			sequences_done, items_in, results_seen);
		$display("%0d sequences overflowed the store; one long output hold applied.",
			overflowed_sequences);
		if (!timed_out && mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/msu_pkg.sv
rtl/msu_stream_if.sv
rtl/msu_ram.sv
rtl/merge_insertion_sorter_unit.sv
tb/sv/tb_merge_insertion_sorter_unit.sv
